>>> src/sbt_pkg.sv
// Shared types, constants and lookup tables for the substitution and
// block transposition cipher. No dependencies.
package sbt_pkg;

  localparam int BLOCK_LEN = 10;
  localparam int CNT_W     = $clog2(BLOCK_LEN + 1);
  localparam int IDX_W     = $clog2(BLOCK_LEN);
  localparam int ALPHA_CNT = 26;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
  } out_item_t;

  // Per-cell control from the block controller.
  typedef struct packed {
    logic wr_en;
    logic load_en;
    logic shift_en;
  } cell_ctrl_t;

  typedef logic [IDX_W-1:0] perm_t [BLOCK_LEN];

  localparam perm_t FWD_PERM = '{4'd6, 4'd2, 4'd7, 4'd5, 4'd1, 4'd3, 4'd4, 4'd9, 4'd0, 4'd8};
  localparam perm_t INV_PERM = '{4'd8, 4'd4, 4'd1, 4'd5, 4'd6, 4'd3, 4'd0, 4'd2, 4'd9, 4'd7};

  typedef byte_t sub_tab_t [ALPHA_CNT];

  localparam sub_tab_t FWD_SUB = '{"N", "A", "S", "I", "J", "K", "C", "M", "Q", "R", "F", "B",
                                   "D", "G", "H", "E", "L", "O", "P", "W", "T", "Z", "Y", "V",
                                   "U", "X"};
  localparam sub_tab_t INV_SUB = '{"B", "L", "G", "M", "P", "K", "N", "O", "D", "E", "F", "Q",
                                   "H", "A", "R", "S", "I", "J", "C", "U", "Y", "X", "T", "Z",
                                   "W", "V"};

endpackage

>>> src/sbt_sub.sv
// Per-character substitution: case folding and the 26-letter table lookup.
// Depends on sbt_pkg.
module sbt_sub (
  input  sbt_pkg::byte_t char_i,
  input  logic           dec_i,
  output sbt_pkg::byte_t char_o
);
  import sbt_pkg::*;

  byte_t      folded;
  logic [4:0] idx;

  always_comb begin
    folded = char_i;
    if (char_i inside {["a":"z"]}) begin
      folded = char_i - 8'd32;
    end
    idx    = 5'(folded - "A");
    char_o = folded;
    if (folded inside {["A":"Z"]}) begin
      char_o = dec_i ? INV_SUB[idx] : FWD_SUB[idx];
    end
  end

endmodule

>>> src/sbt_cell.sv
// One cell of the block row: a collected byte and an output byte that
// shifts to its lower neighbor. Depends on sbt_pkg.
module sbt_cell (
  input  logic                clk,
  input  sbt_pkg::cell_ctrl_t ctrl_i,
  input  sbt_pkg::byte_t      wr_data_i,
  input  sbt_pkg::byte_t      load_data_i,
  input  sbt_pkg::byte_t      shift_in_i,
  output sbt_pkg::byte_t      buf_o,
  output sbt_pkg::byte_t      emit_o
);
  import sbt_pkg::*;

  byte_t buf_r;
  byte_t emit_r;

  always_ff @(posedge clk) begin
    if (ctrl_i.wr_en) begin
      buf_r <= wr_data_i;
    end
    if (ctrl_i.load_en) begin
      emit_r <= load_data_i;
    end else if (ctrl_i.shift_en) begin
      emit_r <= shift_in_i;
    end
  end

  assign buf_o  = buf_r;
  assign emit_o = emit_r;

endmodule

>>> src/substitution_block_transposition_cipher.sv
// Top level of the substitution and block transposition cipher: controller
// and a row of sbt_cell instances. Depends on sbt_pkg, sbt_sub, sbt_cell.
//
//  Channel | Ports                          | Carries
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data    | one byte and last flag
//  output  | out_valid, out_ready, out_data | one byte and end-of-run flag
//  config  | cfg_valid, cfg_ready, cfg_data | decrypt_mode, always ready
//
// Each accepted input byte is substituted and written into the cell at the
// fill position. A full block or a message tail is copied into the output
// row as its closing byte is accepted and then shifts out one byte per
// output transaction, so a full block leaves as ten output transactions.
// Bytes that do not close a block are accepted while a block drains; one
// that closes a block waits until the output row is empty.
// rst_n clears the fill count, the output count and the mode.
module substitution_block_transposition_cipher (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sbt_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sbt_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import sbt_pkg::*;

  logic             decrypt_mode_r;
  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] emit_cnt_r, emit_cnt_nxt;

  logic  in_acc, out_acc, busy, full_now, emit_now;
  byte_t sub_char;
  byte_t buf_q    [BLOCK_LEN];
  byte_t buf_nxt  [BLOCK_LEN];
  byte_t emit_q   [BLOCK_LEN];
  byte_t load_d   [BLOCK_LEN];
  cell_ctrl_t ctrl [BLOCK_LEN];

  assign busy      = (emit_cnt_r != '0);
  assign full_now  = (fill_r == IDX_W'(BLOCK_LEN - 1));
  assign in_ready  = !busy || (!full_now && !in_data.last_char);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = busy;
  assign out_acc   = out_valid && out_ready;
  assign emit_now  = in_acc && (full_now || in_data.last_char);
  assign cfg_ready = 1'b1;

  assign out_data.out_char = emit_q[0];
  assign out_data.run_end  = (emit_cnt_r == CNT_W'(1));

  sbt_sub u_sub (
    .char_i (in_data.in_char),
    .dec_i  (decrypt_mode_r),
    .char_o (sub_char)
  );

  for (genvar i = 0; i < BLOCK_LEN; i++) begin : g_cell
    localparam int FI = FWD_PERM[i];
    localparam int II = INV_PERM[i];

    // The closing byte is not yet in its cell, so the block is taken
    // with that byte merged in.
    assign buf_nxt[i] = (fill_r == IDX_W'(i)) ? sub_char : buf_q[i];

    assign load_d[i] = !full_now      ? buf_nxt[i] :
                       decrypt_mode_r ? buf_nxt[II] : buf_nxt[FI];

    assign ctrl[i].wr_en    = in_acc && (fill_r == IDX_W'(i));
    assign ctrl[i].load_en  = emit_now;
    assign ctrl[i].shift_en = out_acc;

    sbt_cell u_cell (
      .clk         (clk),
      .ctrl_i      (ctrl[i]),
      .wr_data_i   (sub_char),
      .load_data_i (load_d[i]),
      .shift_in_i  ((i == BLOCK_LEN - 1) ? 8'h00 : emit_q[(i + 1) % BLOCK_LEN]),
      .buf_o       (buf_q[i]),
      .emit_o      (emit_q[i])
    );
  end

  always_comb begin
    fill_nxt     = fill_r;
    emit_cnt_nxt = emit_cnt_r;
    if (in_acc) begin
      fill_nxt = emit_now ? '0 : fill_r + IDX_W'(1);
    end
    if (emit_now) begin
      emit_cnt_nxt = full_now ? CNT_W'(BLOCK_LEN) : CNT_W'(fill_r) + CNT_W'(1);
    end else if (out_acc) begin
      emit_cnt_nxt = emit_cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r         <= '0;
      emit_cnt_r     <= '0;
      decrypt_mode_r <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        decrypt_mode_r <= cfg_data;
      end
    end
  end

endmodule

>>> src/sbt_checker.sv
// Port-level checker for the cipher top level, with its bind statement.
// Depends on sbt_pkg and substitution_block_transposition_cipher.
module sbt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input sbt_pkg::out_item_t out_data
);
  import sbt_pkg::*;

  logic [CNT_W-1:0] beat_r;
  logic             out_acc;

  assign out_acc = out_valid && out_ready;

  // Output transactions since the last end of run.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else if (out_acc) begin
      beat_r <= out_data.run_end ? '0 : beat_r + CNT_W'(1);
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  a_run_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_data.run_end |=> out_valid)
    else $error("gap inside an output run");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> beat_r < CNT_W'(BLOCK_LEN) &&
    (beat_r != CNT_W'(BLOCK_LEN - 1) || out_data.run_end))
    else $error("output run longer than one block");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no output pending");

endmodule

bind substitution_block_transposition_cipher sbt_checker u_sbt_checker (.*);
